// ===== rtl/core/alpha_overlay_compositor_defines.svh =====
// assertion macros shared by the compositor checker
// no dependencies; included by aoc_checker.sv
`ifndef ALPHA_OVERLAY_COMPOSITOR_DEFINES_SVH
`define ALPHA_OVERLAY_COMPOSITOR_DEFINES_SVH

// antecedent in this cycle implies consequent in the next cycle
`define AOC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("compositor check failed");

// antecedent implies consequent in the same cycle
`define AOC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("compositor check failed");

`endif

// ===== rtl/core/aoc_pkg.sv =====
// shared types and constants of the alpha overlay compositor
// no dependencies; imported by the top level, front end, queue and back end
package aoc_pkg;

    localparam int DEFAULT_MAX_DIM = 4096;

    // depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // configuration register widths and reset values
    localparam int DIM_W = 13;
    localparam int OFS_W = 12;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_INDEX_W = 3;

    localparam logic [DIM_W-1:0] RST_BG_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0] RST_BG_HEIGHT = 13'd480;

    // full opacity and exact division by 255 for sums below 2^16
    localparam logic [7:0]  MASK_MAX     = 8'd255;
    localparam logic [16:0] DIV255_RECIP = 17'd32897;
    localparam int          DIV255_SHIFT = 23;

    localparam int NUM_CH = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BG_WIDTH    = 3'd0,
        REG_BG_HEIGHT   = 3'd1,
        REG_FG_WIDTH    = 3'd2,
        REG_FG_HEIGHT   = 3'd3,
        REG_MASK_WIDTH  = 3'd4,
        REG_MASK_HEIGHT = 3'd5,
        REG_X_OFFSET    = 3'd6,
        REG_Y_OFFSET    = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [DIM_W-1:0] bg_width;
        logic [DIM_W-1:0] bg_height;
        logic [DIM_W-1:0] fg_width;
        logic [DIM_W-1:0] fg_height;
        logic [DIM_W-1:0] mask_width;
        logic [DIM_W-1:0] mask_height;
        logic [OFS_W-1:0] x_offset;
        logic [OFS_W-1:0] y_offset;
    } cfg_t;

    // one classified pixel, channel 0 red, 1 green, 2 blue
    typedef struct packed {
        logic [NUM_CH-1:0][7:0] bg;
        logic [NUM_CH-1:0][7:0] fg;
        logic [7:0]             mask;
        logic                   in_window;
        logic                   frame_end;
    } item_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

endpackage

// ===== rtl/core/alpha_overlay_compositor.sv =====
// top level of the alpha overlay compositor: configuration registers and wiring
// depends on aoc_pkg, aoc_front, aoc_queue, aoc_back
//
// Blends an overlay into a raster-order background stream, one pixel per clock while
// the output is free. A pixel taken on the slave side passes the queue, the sum
// register and the output register; the blend runs as two pipeline stages (weighted
// sum, then division by 255 through a reciprocal multiply). A four-entry queue
// between the classifying front end and the blend lets input keep flowing for four
// pixels while the output is stalled. Configuration writes take effect at once
// and should be made while no pixel is in flight; they never reset the position.
module alpha_overlay_compositor
    import aoc_pkg::*;
#(
    parameter int MAX_DIM = DEFAULT_MAX_DIM
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // bg_red, bg_green, bg_blue, fg_red, fg_green, fg_blue, mask_value
    input  logic [55:0]            s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // out_red, out_green, out_blue
    output logic [23:0]            m_tdata,
    // frame_end
    output logic                   m_tlast
);

    cfg_t          cfg_reg, cfg_next;
    queue_status_t qs;
    logic          push, pop;
    item_t         push_item, head;

    // register writes
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_BG_WIDTH:    cfg_next.bg_width    = cfg_data;
                REG_BG_HEIGHT:   cfg_next.bg_height   = cfg_data;
                REG_FG_WIDTH:    cfg_next.fg_width    = cfg_data;
                REG_FG_HEIGHT:   cfg_next.fg_height   = cfg_data;
                REG_MASK_WIDTH:  cfg_next.mask_width  = cfg_data;
                REG_MASK_HEIGHT: cfg_next.mask_height = cfg_data;
                REG_X_OFFSET:    cfg_next.x_offset    = cfg_data[OFS_W-1:0];
                REG_Y_OFFSET:    cfg_next.y_offset    = cfg_data[OFS_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{bg_width:    RST_BG_WIDTH,
                         bg_height:   RST_BG_HEIGHT,
                         fg_width:    '0,
                         fg_height:   '0,
                         mask_width:  '0,
                         mask_height: '0,
                         x_offset:    '0,
                         y_offset:    '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // front end
    aoc_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .qs       (qs),
        .push     (push),
        .item     (push_item)
    );

    // queue
    aoc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .qs        (qs)
    );

    // blend back end
    aoc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .qs       (qs),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/core/aoc_front.sv =====
// front end: input transfer, position counters and window classification
// depends on aoc_pkg
module aoc_front
    import aoc_pkg::*;
#(
    parameter int MAX_DIM = DEFAULT_MAX_DIM
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  cfg_t          cfg,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [55:0]   s_tdata,
    input  queue_status_t qs,
    output logic          push,
    output item_t         item
);

    localparam int CW   = $clog2(MAX_DIM);
    localparam int CMPW = (CW + 1 > OFS_W + 2) ? CW + 1 : OFS_W + 2;

    logic [CW-1:0]   col_reg, col_next, row_reg, row_next;
    logic [CMPW-1:0] w, h, bgw_ext, bgh_ext;
    logic [DIM_W-1:0] span_w, span_h;
    logic [CMPW-1:0] x_lo, x_hi, y_lo, y_hi, col_ext, row_ext, col_inc, row_inc;
    logic            in_x, in_y, line_end, last_row;

    assign s_tready = !qs.full;
    assign push     = s_tvalid && s_tready;

    // clamp background size, window edges
    always_comb
    begin
        bgw_ext = CMPW'(cfg.bg_width);
        bgh_ext = CMPW'(cfg.bg_height);
        if (bgw_ext == '0)
            w = CMPW'(1);
        else if (bgw_ext > CMPW'(MAX_DIM))
            w = CMPW'(MAX_DIM);
        else
            w = bgw_ext;
        if (bgh_ext == '0)
            h = CMPW'(1);
        else if (bgh_ext > CMPW'(MAX_DIM))
            h = CMPW'(MAX_DIM);
        else
            h = bgh_ext;
        span_w = (cfg.fg_width < cfg.mask_width) ? cfg.fg_width : cfg.mask_width;
        span_h = (cfg.fg_height < cfg.mask_height) ? cfg.fg_height : cfg.mask_height;
        x_lo = CMPW'(cfg.x_offset);
        y_lo = CMPW'(cfg.y_offset);
        x_hi = x_lo + CMPW'(span_w);
        y_hi = y_lo + CMPW'(span_h);
    end

    // classification and next position
    always_comb
    begin
        col_ext  = CMPW'(col_reg);
        row_ext  = CMPW'(row_reg);
        col_inc  = col_ext + CMPW'(1);
        row_inc  = row_ext + CMPW'(1);
        in_x     = (col_ext < w) && (col_ext >= x_lo) && (col_ext < x_hi);
        in_y     = (row_ext < h) && (row_ext >= y_lo) && (row_ext < y_hi);
        line_end = col_inc >= w;
        last_row = row_inc >= h;
        col_next = col_reg;
        row_next = row_reg;
        if (push)
        begin
            if (line_end)
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_inc[CW-1:0];
            end
            else
            begin
                col_next = col_inc[CW-1:0];
            end
        end
    end

    // item unpacking, lowest byte first
    always_comb
    begin
        item.bg[0]     = s_tdata[7:0];
        item.bg[1]     = s_tdata[15:8];
        item.bg[2]     = s_tdata[23:16];
        item.fg[0]     = s_tdata[31:24];
        item.fg[1]     = s_tdata[39:32];
        item.fg[2]     = s_tdata[47:40];
        item.mask      = s_tdata[55:48];
        item.in_window = in_x && in_y;
        item.frame_end = line_end && last_row;
    end

    // position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ===== rtl/core/aoc_queue.sv =====
// short fifo of classified pixels between front and back
// depends on aoc_pkg
module aoc_queue
    import aoc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  item_t         push_item,
    input  logic          pop,
    output item_t         head,
    output queue_status_t qs
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    item_t            entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]    count_reg, count_next;

    assign qs.empty = (count_reg == '0);
    assign qs.full  = (count_reg == NW'(QUEUE_DEPTH));
    assign head     = entry_reg[rd_ptr_reg];

    // pointer and fill level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + NW'(1);
        else if (pop && !push)
            count_next = count_reg - NW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== rtl/core/aoc_back.sv =====
// back end: two-stage blend pipeline whose second stage is the output register
// depends on aoc_pkg
module aoc_back
    import aoc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  item_t         head,
    input  queue_status_t qs,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [23:0]   m_tdata,
    output logic          m_tlast
);

    logic                    advance;
    logic                    s1_valid_reg, s1_valid_next, out_valid_reg, out_valid_next;
    logic [NUM_CH-1:0][15:0] sum_reg, sum_next;
    logic [NUM_CH-1:0][7:0]  s1_bg_reg;
    logic                    s1_inside_reg, s1_last_reg;
    logic [NUM_CH-1:0][7:0]  out_reg, out_next;
    logic                    out_last_reg;
    logic [15:0]             prod_b, prod_f;
    logic [16:0]             sum_w;
    logic [32:0]             quot_w;

    assign advance  = !out_valid_reg || m_tready;
    assign pop      = advance && !qs.empty;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg[2], out_reg[1], out_reg[0]};
    assign m_tlast  = out_last_reg;

    // weighted sum bg*(255-m) + fg*m per channel
    always_comb
    begin
        sum_next = sum_reg;
        prod_b   = '0;
        prod_f   = '0;
        sum_w    = '0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            prod_b      = 16'(head.bg[c]) * 16'(MASK_MAX - head.mask);
            prod_f      = 16'(head.fg[c]) * 16'(head.mask);
            sum_w       = 17'(prod_b) + 17'(prod_f);
            sum_next[c] = sum_w[15:0];
        end
    end

    // divide by 255 through reciprocal, or pass background
    always_comb
    begin
        out_next = out_reg;
        quot_w   = '0;
        for (int c = 0; c < NUM_CH; c++)
        begin
            quot_w      = 33'(sum_reg[c]) * 33'(DIV255_RECIP);
            out_next[c] = s1_inside_reg ? quot_w[DIV255_SHIFT +: 8] : s1_bg_reg[c];
        end
    end

    // stage valids
    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            s1_valid_next  = !qs.empty;
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sum_reg       <= sum_next;
            s1_bg_reg     <= head.bg;
            s1_inside_reg <= head.in_window;
            s1_last_reg   <= head.frame_end;
            out_reg       <= out_next;
            out_last_reg  <= s1_last_reg;
        end
    end

endmodule

// ===== rtl/core/aoc_checker.sv =====
// port-level checks of the compositor, bound to the top level
// depends on alpha_overlay_compositor_defines.svh and alpha_overlay_compositor
`include "alpha_overlay_compositor_defines.svh"

module aoc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // a stalled result stays offered
    `AOC_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)

    // a stalled result keeps its payload
    `AOC_ASSERT_NEXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))

    // input back-pressure only follows a stalled output
    `AOC_ASSERT_NOW(a_stall_cause, clk, rst_n, !s_tready, $past(m_tvalid && !m_tready))

    // a full queue frees a slot once the output is taken
    `AOC_ASSERT_NEXT(a_stall_release, clk, rst_n, m_tvalid && m_tready && !s_tready, s_tready)

endmodule

bind alpha_overlay_compositor aoc_checker u_aoc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== test/alpha_overlay_compositor_tb.sv =====
// self-checking testbench for the alpha overlay compositor: directed rows, then random frames
// depends on aoc_pkg and alpha_overlay_compositor; drives both stream sides with random idling
// and checks every output transfer against a given or a built-in predicted pixel
module alpha_overlay_compositor_tb;
    import aoc_pkg::*;

    localparam int NUM_REGS       = 8;
    localparam int DIR_SETTINGS   = 6;
    localparam int KEEP_RESET     = 0;
    localparam int SETTLE_CYCLES  = 8;
    localparam int ITEMS_PER_MODE = 430;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int FULL_OPACITY   = 255;
    localparam int SMALL_EDGE     = 48;

    // input transfer layout, red lowest within each group
    typedef struct packed {
        logic [7:0]             mask;
        logic [NUM_CH-1:0][7:0] fg;
        logic [NUM_CH-1:0][7:0] bg;
    } pixel_in_t;

    typedef struct {
        logic [NUM_CH-1:0][7:0] rgb;
        logic                   frame_end;
    } pixel_out_t;

    typedef struct {
        int         setting;
        pixel_in_t  pix;
        bit         typed;
        pixel_out_t want;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [55:0]            s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [23:0]            m_tdata;
    logic                   m_tlast;

    // predictor copy of the registers and raster position
    logic [CFG_DATA_W-1:0] cfg_regs [NUM_REGS];
    logic [CFG_DATA_W-1:0] next_settings [NUM_REGS];
    int unsigned           col_pos;
    int unsigned           row_pos;

    pixel_out_t pixels_due [$];
    stim_row_t  stim_rows [$];
    int         errors = 0;
    int         send_idle_pct;
    int         recv_stall_pct;
    int         stalled_cycles;
    string      chan_name [NUM_CH] = '{"red", "green", "blue"};

    // register sets for the directed rows, in register index order
    logic [CFG_DATA_W-1:0] dir_settings [DIR_SETTINGS][NUM_REGS] = '{
        '{13'd640,  13'd480,  13'd0,    13'd0,    13'd0,    13'd0,    13'd0, 13'd0},
        '{13'd4,    13'd2,    13'd4,    13'd2,    13'd4,    13'd2,    13'd0, 13'd0},
        '{13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0,    13'd0, 13'd0},
        '{13'd8191, 13'd8191, 13'd4096, 13'd4096, 13'd4096, 13'd4096, 13'd0, 13'd0},
        '{13'd3,    13'd3,    13'd2,    13'd5,    13'd5,    13'd2,    13'd1, 13'd1},
        '{13'd4,    13'd2,    13'd4,    13'd2,    13'd4,    13'd2,    13'd4, 13'd4095}
    };

    alpha_overlay_compositor u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // background size as used for counting, clamped to one..maximum
    function automatic int unsigned dim_limit(int unsigned v);
        if (v < 1) return 1;
        if (v > DEFAULT_MAX_DIM) return DEFAULT_MAX_DIM;
        return v;
    endfunction

    function automatic bit in_window_span(int unsigned pos, int unsigned off,
                                          int unsigned span, int unsigned limit);
        if (pos >= limit || pos < off) return 1'b0;
        return (pos - off) < span;
    endfunction

    // blended pixel and frame flag for one background pixel, advances the position
    function automatic pixel_out_t composite_pixel(pixel_in_t p);
        int unsigned w, h, span_w, span_h, m, b, f;
        bit          in_win, line_end, last_row;
        int          c;
        pixel_out_t  r;
        w      = dim_limit(cfg_regs[REG_BG_WIDTH]);
        h      = dim_limit(cfg_regs[REG_BG_HEIGHT]);
        span_w = (cfg_regs[REG_FG_WIDTH] < cfg_regs[REG_MASK_WIDTH]) ?
                 cfg_regs[REG_FG_WIDTH] : cfg_regs[REG_MASK_WIDTH];
        span_h = (cfg_regs[REG_FG_HEIGHT] < cfg_regs[REG_MASK_HEIGHT]) ?
                 cfg_regs[REG_FG_HEIGHT] : cfg_regs[REG_MASK_HEIGHT];
        m      = p.mask;
        in_win = in_window_span(col_pos, cfg_regs[REG_X_OFFSET], span_w, w) &&
                 in_window_span(row_pos, cfg_regs[REG_Y_OFFSET], span_h, h);
        for (c = 0; c < NUM_CH; c++)
        begin
            b = p.bg[c];
            f = p.fg[c];
            r.rgb[c] = in_win ? 8'((b * (FULL_OPACITY - m) + f * m) / FULL_OPACITY) : p.bg[c];
        end
        line_end    = (col_pos + 1) >= w;
        last_row    = (row_pos + 1) >= h;
        r.frame_end = line_end && last_row;
        if (line_end)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end
        else
            col_pos = col_pos + 1;
        return r;
    endfunction

    function automatic void add_row(int setting, logic [23:0] bg, logic [23:0] fg,
                                    logic [7:0] m, bit typed, logic [23:0] rgb,
                                    logic last);
        stim_row_t r;
        r.setting        = setting;
        r.pix.bg         = bg;
        r.pix.fg         = fg;
        r.pix.mask       = m;
        r.typed          = typed;
        r.want.rgb       = rgb;
        r.want.frame_end = last;
        stim_rows.push_back(r);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] bg_dim();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return CFG_DATA_W'($urandom_range(1, 8));
        if (r < 90) return CFG_DATA_W'($urandom_range(9, SMALL_EDGE));
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return CFG_DATA_W'(DEFAULT_MAX_DIM);
            2:       return '1;
            default: return CFG_DATA_W'($urandom());
        endcase
    endfunction

    // window sizes and offsets mostly near the background, now and then anywhere
    function automatic logic [CFG_DATA_W-1:0] window_val(int unsigned e, bit is_offset);
        if ($urandom_range(0, 99) >= 85) return CFG_DATA_W'($urandom());
        return CFG_DATA_W'($urandom_range(0, is_offset ? e : e + 2));
    endfunction

    function automatic void randomise_settings();
        int unsigned ew, eh;
        next_settings[REG_BG_WIDTH]    = bg_dim();
        next_settings[REG_BG_HEIGHT]   = bg_dim();
        ew = dim_limit(next_settings[REG_BG_WIDTH]);
        eh = dim_limit(next_settings[REG_BG_HEIGHT]);
        ew = (ew > SMALL_EDGE) ? SMALL_EDGE : ew;
        eh = (eh > SMALL_EDGE) ? SMALL_EDGE : eh;
        next_settings[REG_FG_WIDTH]    = window_val(ew, 1'b0);
        next_settings[REG_FG_HEIGHT]   = window_val(eh, 1'b0);
        next_settings[REG_MASK_WIDTH]  = window_val(ew, 1'b0);
        next_settings[REG_MASK_HEIGHT] = window_val(eh, 1'b0);
        next_settings[REG_X_OFFSET]    = window_val(ew, 1'b1);
        next_settings[REG_Y_OFFSET]    = window_val(eh, 1'b1);
    endfunction

    function automatic pixel_in_t random_pixel();
        logic [63:0] raw;
        pixel_in_t   p;
        raw = {$urandom(), $urandom()};
        p   = raw[55:0];
        case ($urandom_range(0, 9))
            0, 1:    p.mask = 8'h00;
            2, 3:    p.mask = 8'hff;
            default: ;
        endcase
        return p;
    endfunction

    // one register per cycle, offsets keep only their low bits
    task automatic write_settings();
        int i;
        for (i = 0; i < NUM_REGS; i++)
        begin
            cfg_we    = 1'b1;
            cfg_index = cfg_index_t'(i);
            cfg_data  = next_settings[i];
            @(negedge clk);
            if (cfg_index_t'(i) == REG_X_OFFSET || cfg_index_t'(i) == REG_Y_OFFSET)
                cfg_regs[i] = next_settings[i] & {1'b0, {OFS_W{1'b1}}};
            else
                cfg_regs[i] = next_settings[i];
        end
        cfg_we = 1'b0;
    endtask

    // stop sending and let the pipeline empty
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (pixels_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // one input transfer, called and returning at a falling edge
    task automatic put_pixel(pixel_in_t p, bit typed, pixel_out_t want);
        pixel_out_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = p;
        do
            @(posedge clk);
        while (!s_tready);
        predicted = composite_pixel(p);
        if (typed)
            pixels_due.push_back(want);
        else
            pixels_due.push_back(predicted);
        @(negedge clk);
    endtask

    // output side back-pressure
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // compare each output transfer with the oldest expected pixel
    always @(posedge clk)
    begin : check_outputs
        pixel_out_t want;
        int         c;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pixels_due.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected output transfer, expected none, got %h last %b",
                         $time, m_tdata, m_tlast);
            end
            else
            begin
                want = pixels_due.pop_front();
                for (c = 0; c < NUM_CH; c++)
                    if (m_tdata[8*c +: 8] !== want.rgb[c])
                    begin
                        errors++;
                        $display("%0t: %s mismatch, expected %h, got %h",
                                 $time, chan_name[c], want.rgb[c], m_tdata[8*c +: 8]);
                    end
                if (m_tlast !== want.frame_end)
                begin
                    errors++;
                    $display("%0t: frame end mismatch, expected %b, got %b",
                             $time, want.frame_end, m_tlast);
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stalled_cycles <= 0;
        else if (stalled_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
        else
            stalled_cycles <= stalled_cycles + 1;
    end

    initial
    begin : stimulus
        int         i, mode, n, k, cur;
        pixel_out_t none;
        cfg_we         = 1'b0;
        cfg_index      = REG_BG_WIDTH;
        cfg_data       = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        rst_n          = 1'b0;
        send_idle_pct  = 22;
        recv_stall_pct = 74;
        none.rgb       = '0;
        none.frame_end = 1'b0;
        cfg_regs       = dir_settings[KEEP_RESET];
        col_pos        = 0;
        row_pos        = 0;

        // reset values: plain pass-through at the start of a large frame
        add_row(0, 24'h000000, 24'hffffff, 8'hff, 1, 24'h000000, 1'b0);
        add_row(0, 24'hffffff, 24'h000000, 8'hff, 1, 24'hffffff, 1'b0);
        add_row(0, 24'ha5a5a5, 24'h5a5a5a, 8'h80, 1, 24'ha5a5a5, 1'b0);
        add_row(0, 24'h123456, 24'hfedcba, 8'h00, 1, 24'h123456, 1'b0);
        // whole frame blended, first pixel ends the line after the size shrinks
        add_row(1, 24'h000000, 24'hffffff, 8'hff, 0, 24'h0, 1'b0);
        add_row(1, 24'hffffff, 24'h000000, 8'h00, 0, 24'h0, 1'b0);
        add_row(1, 24'h000000, 24'hffffff, 8'hff, 0, 24'h0, 1'b0);
        add_row(1, 24'hffffff, 24'h000000, 8'hff, 0, 24'h0, 1'b0);
        add_row(1, 24'h808080, 24'h7f7f7f, 8'h80, 0, 24'h0, 1'b0);
        add_row(1, 24'hff00ff, 24'h00ff00, 8'h01, 0, 24'h0, 1'b0);
        add_row(1, 24'h00ff00, 24'hff00ff, 8'hfe, 0, 24'h0, 1'b0);
        add_row(1, 24'hffffff, 24'hffffff, 8'h55, 0, 24'h0, 1'b0);
        add_row(1, 24'h102030, 24'h405060, 8'haa, 0, 24'h0, 1'b0);
        // zero background size clamps to one pixel: every pixel ends the frame
        add_row(2, 24'hffffff, 24'h000000, 8'hff, 1, 24'hffffff, 1'b1);
        add_row(2, 24'h000000, 24'hffffff, 8'hff, 1, 24'h000000, 1'b1);
        // oversized background and full-size window
        add_row(3, 24'h0f0f0f, 24'hf0f0f0, 8'hc0, 0, 24'h0, 1'b0);
        add_row(3, 24'hffffff, 24'h000000, 8'h7f, 0, 24'h0, 1'b0);
        // window clipped by the smaller of foreground and mask
        add_row(4, 24'h112233, 24'h445566, 8'hff, 0, 24'h0, 1'b0);
        add_row(4, 24'h778899, 24'haabbcc, 8'h40, 0, 24'h0, 1'b0);
        add_row(4, 24'hddeeff, 24'h001122, 8'h80, 0, 24'h0, 1'b0);
        add_row(4, 24'h334455, 24'h667788, 8'hff, 0, 24'h0, 1'b0);
        add_row(4, 24'h99aabb, 24'hccddee, 8'h01, 0, 24'h0, 1'b0);
        add_row(4, 24'hffffff, 24'h000000, 8'hfe, 0, 24'h0, 1'b0);
        // offsets at and beyond the edge: empty window
        add_row(5, 24'h00ff00, 24'hff00ff, 8'hff, 0, 24'h0, 1'b0);
        add_row(5, 24'hff00ff, 24'h00ff00, 8'hff, 0, 24'h0, 1'b0);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed rows, registers rewritten whenever the set changes
        cur = KEEP_RESET;
        for (i = 0; i < stim_rows.size(); i++)
        begin
            if (stim_rows[i].setting != cur)
            begin
                wait_idle();
                cur           = stim_rows[i].setting;
                next_settings = dir_settings[cur];
                write_settings();
            end
            put_pixel(stim_rows[i].pix, stim_rows[i].typed, stim_rows[i].want);
        end

        // random frames under three idling patterns
        for (mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:       begin send_idle_pct = 22; recv_stall_pct = 74; end
                1:       begin send_idle_pct = 74; recv_stall_pct = 22; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            k = 0;
            while (k < ITEMS_PER_MODE)
            begin
                wait_idle();
                randomise_settings();
                write_settings();
                n = $urandom_range(8, 60);
                repeat (n) put_pixel(random_pixel(), 1'b0, none);
                k += n;
            end
        end

        wait_idle();
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
